/* design/aih_pkg.sv */
// aih_pkg: shared types, constants and helpers for the archive index hasher
// used by aih_front, aih_queue, aih_back and archive_index_hasher_unit
`default_nettype none

package aih_pkg;

    // header layout
    localparam int unsigned PHASE_W     = 5;
    localparam logic [4:0]  PHASE_NAME0 = 5'd0;
    localparam logic [4:0]  NAME_LEN    = 5'd13;
    localparam logic [4:0]  STORE_LEN   = 5'd12;
    localparam logic [4:0]  PHASE_LEN0  = 5'd13;
    localparam logic [4:0]  PHASE_LEN1  = 5'd14;
    localparam logic [4:0]  PHASE_LEN2  = 5'd15;
    localparam logic [4:0]  PHASE_LEN3  = 5'd16;
    localparam logic [4:0]  PHASE_DATA  = 5'd17;

    // configuration register map
    localparam int unsigned CFG_INDEX_W       = 3;
    localparam int unsigned CFG_DATA_W        = 4;
    localparam logic [2:0]  CFG_HASH_INDEX_0  = 3'd0;
    localparam logic [2:0]  CFG_HASH_INDEX_1  = 3'd1;
    localparam logic [2:0]  CFG_HASH_INDEX_2  = 3'd2;
    localparam logic [2:0]  CFG_HASH_INDEX_3  = 3'd3;

    // reset positions, entry 0 lands in hash bits 31..24
    localparam logic [3:0][3:0] HASH_INDEX_RESET = {4'd7, 4'd6, 4'd1, 4'd0};

    // ascii case folding
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_FLIP    = 8'h20;

    // default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // one classified header or end-of-stream event
    typedef struct packed {
        logic            entry_valid;
        logic            stream_done;
        logic [3:0][7:0] sel_bytes;
        logic [15:0]     name_sum;
        logic [7:0]      name_xor;
        logic [31:0]     entry_offset;
        logic [15:0]     entry_total;
    } event_t;

    // fold a-z to upper case
    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        logic [7:0] r;
        begin
            r = c;
            if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            begin
                r = c ^ CASE_FLIP;
            end
            return r;
        end
    endfunction

    // sign-extend a byte to 32 bits
    function automatic logic [31:0] sext8(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

endpackage

`default_nettype wire

/* design/aih_front.sv */
// aih_front: byte stream parser, holds the scan state and the hash positions
// depends on aih_pkg; produces one aih_pkg::event_t per header or last byte
`default_nettype none

module aih_front
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // stream input
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [7:0]                          archive_byte,
    input  wire logic                                last_byte,
    // configuration writes
    input  wire logic                                cfg_valid,
    input  wire logic [aih_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [aih_pkg::CFG_DATA_W-1:0]      cfg_data,
    // event push toward the queue
    output logic                                     ev_push,
    output aih_pkg::event_t                          ev_data,
    input  wire logic                                ev_full
);

    logic [3:0][3:0]                     hash_index_reg;
    logic [aih_pkg::PHASE_W-1:0]         phase_reg, phase_next;
    logic [15:0]                         sum_reg, sum_next;
    logic [7:0]                          xor_reg, xor_next;
    logic                                term_reg, term_next;
    logic [23:0]                         len_reg, len_next;
    logic [31:0]                         remain_reg, remain_next;
    logic [31:0]                         pos_reg, pos_next;
    logic [31:0]                         start_reg, start_next;
    logic [15:0]                         count_reg, count_next;
    logic [3:0][7:0]                     sel_reg, sel_next;
    logic                                accept;
    logic                                header_done;

    assign in_ready = !ev_full;
    assign accept   = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_index_reg <= aih_pkg::HASH_INDEX_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                aih_pkg::CFG_HASH_INDEX_0: hash_index_reg[0] <= cfg_data;
                aih_pkg::CFG_HASH_INDEX_1: hash_index_reg[1] <= cfg_data;
                aih_pkg::CFG_HASH_INDEX_2: hash_index_reg[2] <= cfg_data;
                aih_pkg::CFG_HASH_INDEX_3: hash_index_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // scan step for one accepted byte
    always_comb
    begin
        logic        phase0;
        logic [15:0] sum_base;
        logic [7:0]  xor_base;
        logic        term_base;
        logic        term_now;
        logic [7:0]  c;
        logic [31:0] length_full;
        logic [31:0] remain_dec;

        phase0    = (phase_reg == aih_pkg::PHASE_NAME0);
        sum_base  = phase0 ? 16'd0 : sum_reg;
        xor_base  = phase0 ? 8'd0 : xor_reg;
        term_base = phase0 ? 1'b0 : term_reg;
        term_now  = term_base || (archive_byte == 8'd0);
        c         = term_now ? 8'd0 : aih_pkg::fold_upper(archive_byte);
        length_full = {archive_byte, len_reg};
        remain_dec  = remain_reg - {31'd0, (remain_reg != 32'd0)};

        phase_next  = phase_reg;
        sum_next    = sum_reg;
        xor_next    = xor_reg;
        term_next   = term_reg;
        len_next    = len_reg;
        remain_next = remain_reg;
        pos_next    = pos_reg + 32'd1;
        start_next  = phase0 ? pos_reg : start_reg;
        count_next  = count_reg;
        sel_next    = sel_reg;
        header_done = 1'b0;

        if (phase_reg < aih_pkg::NAME_LEN)
        begin
            // name byte: fold, accumulate and capture selected positions
            sum_next   = sum_base + {8'd0, c};
            xor_next   = xor_base ^ c;
            term_next  = term_now;
            phase_next = phase_reg + 5'd1;
            for (int k = 0; k < 4; k++)
            begin
                if (phase0)
                begin
                    sel_next[k] = (hash_index_reg[k] == 4'd0) ? c : 8'd0;
                end
                else if (phase_reg < aih_pkg::STORE_LEN
                         && {1'b0, hash_index_reg[k]} == phase_reg)
                begin
                    sel_next[k] = c;
                end
            end
        end
        else if (phase_reg < aih_pkg::PHASE_DATA)
        begin
            // length byte, little endian
            phase_next = phase_reg + 5'd1;
            case (phase_reg)
                aih_pkg::PHASE_LEN0: len_next[7:0]   = archive_byte;
                aih_pkg::PHASE_LEN1: len_next[15:8]  = archive_byte;
                aih_pkg::PHASE_LEN2: len_next[23:16] = archive_byte;
                aih_pkg::PHASE_LEN3:
                begin
                    header_done = 1'b1;
                    count_next  = count_reg + 16'd1;
                    remain_next = length_full;
                    phase_next  = (length_full == 32'd0) ? aih_pkg::PHASE_NAME0
                                                         : aih_pkg::PHASE_DATA;
                end
                default: ;
            endcase
        end
        else
        begin
            // data byte, skipped
            remain_next = remain_dec;
            if (remain_dec == 32'd0)
            begin
                phase_next = aih_pkg::PHASE_NAME0;
            end
        end

        // end of archive returns the scan to its start
        if (last_byte)
        begin
            phase_next  = aih_pkg::PHASE_NAME0;
            sum_next    = 16'd0;
            xor_next    = 8'd0;
            term_next   = 1'b0;
            len_next    = 24'd0;
            remain_next = 32'd0;
            pos_next    = 32'd0;
            start_next  = 32'd0;
            count_next  = 16'd0;
        end
    end

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= aih_pkg::PHASE_NAME0;
            sum_reg    <= 16'd0;
            xor_reg    <= 8'd0;
            term_reg   <= 1'b0;
            len_reg    <= 24'd0;
            remain_reg <= 32'd0;
            pos_reg    <= 32'd0;
            start_reg  <= 32'd0;
            count_reg  <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            sum_reg    <= sum_next;
            xor_reg    <= xor_next;
            term_reg   <= term_next;
            len_reg    <= len_next;
            remain_reg <= remain_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            count_reg  <= count_next;
        end
    end

    // selected name bytes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sel_reg <= sel_next;
        end
    end

    // event toward the back end
    always_comb
    begin
        ev_push              = accept && (header_done || last_byte);
        ev_data.entry_valid  = header_done;
        ev_data.stream_done  = last_byte;
        ev_data.sel_bytes    = header_done ? sel_reg : '0;
        ev_data.name_sum     = header_done ? sum_reg : 16'd0;
        ev_data.name_xor     = header_done ? xor_reg : 8'd0;
        ev_data.entry_offset = header_done ? start_reg : 32'd0;
        ev_data.entry_total  = header_done ? count_reg + 16'd1 : count_reg;
    end

endmodule

`default_nettype wire

/* design/aih_queue.sv */
// aih_queue: small register queue of events between front and back
// depends on aih_pkg for the event type
`default_nettype none

module aih_queue
#(
    parameter int unsigned Depth = aih_pkg::QUEUE_DEPTH
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire aih_pkg::event_t push_data,
    output logic                 full,
    output logic                 pop_valid,
    input  wire logic            pop,
    output aih_pkg::event_t      pop_data
);

    localparam int unsigned PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CNT_W = $clog2(Depth + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(Depth - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(Depth);

    aih_pkg::event_t      slot_reg [Depth];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 do_push, do_pop;

    assign full      = (cnt_reg == CNT_FULL);
    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* design/aih_back.sv */
// aih_back: two-stage hash unit, multiply stage then add into the output register
// depends on aih_pkg for the event type and sign extension
`default_nettype none

module aih_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    // event from the queue
    input  wire logic            ev_valid,
    output logic                 ev_pop,
    input  wire aih_pkg::event_t ev_data,
    // result output
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic                 entry_valid,
    output logic [31:0]          name_hash,
    output logic [31:0]          entry_offset,
    output logic                 stream_done,
    output logic [15:0]          entry_total
);

    logic         s1_valid_reg;
    logic         s1_entry_reg;
    logic         s1_done_reg;
    logic [31:0]  s1_offset_reg;
    logic [15:0]  s1_total_reg;
    logic [31:0]  s1_base_reg, s1_base_next;
    logic [15:0]  s1_prod_reg;
    logic [23:0]  prod_full;
    logic         out_valid_reg;
    logic         out_entry_reg;
    logic         out_done_reg;
    logic [31:0]  out_hash_reg;
    logic [31:0]  out_offset_reg;
    logic [15:0]  out_total_reg;
    logic         s1_load, s2_load;

    assign s2_load = !out_valid_reg || out_ready;
    assign s1_load = !s1_valid_reg || s2_load;
    assign ev_pop  = ev_valid && s1_load;

    // byte shift-in and sum times xor
    assign prod_full = {8'd0, ev_data.name_sum} * {16'd0, ev_data.name_xor};
    assign s1_base_next = (aih_pkg::sext8(ev_data.sel_bytes[0]) << 24)
                        + (aih_pkg::sext8(ev_data.sel_bytes[1]) << 16)
                        + (aih_pkg::sext8(ev_data.sel_bytes[2]) << 8)
                        + aih_pkg::sext8(ev_data.sel_bytes[3]);

    // stage one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= ev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_pop)
        begin
            s1_entry_reg  <= ev_data.entry_valid;
            s1_done_reg   <= ev_data.stream_done;
            s1_offset_reg <= ev_data.entry_offset;
            s1_total_reg  <= ev_data.entry_total;
            s1_base_reg   <= s1_base_next;
            s1_prod_reg   <= prod_full[15:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            out_entry_reg  <= s1_entry_reg;
            out_done_reg   <= s1_done_reg;
            out_offset_reg <= s1_offset_reg;
            out_total_reg  <= s1_total_reg;
            out_hash_reg   <= s1_base_reg + {{16{s1_prod_reg[15]}}, s1_prod_reg};
        end
    end

    assign out_valid    = out_valid_reg;
    assign entry_valid  = out_entry_reg;
    assign name_hash    = out_hash_reg;
    assign entry_offset = out_offset_reg;
    assign stream_done  = out_done_reg;
    assign entry_total  = out_total_reg;

endmodule

`default_nettype wire

/* design/archive_index_hasher_unit.sv */
// archive_index_hasher_unit: top level, front parser, event queue and hash unit
// depends on aih_pkg, aih_front, aih_queue and aih_back
//
// usage
//   in channel: one archive byte per transfer, last_byte marks the end of the archive.
//   out channel: one transfer per completed 17-byte entry header and one for the last
//   byte (stream_done set, entry_valid set too if that byte closed a header).
//   bytes that close nothing produce no transfer.
//   cfg channel: cfg_index 0..3 writes hash_index_0..3, other indices are ignored;
//   cfg_ready is always high, write only while the block is idle.
// timing
//   one byte per cycle sustained; the parser accepts whenever the event queue has room.
//   a result is registered in the event queue, stage one and the output register, in that order.
//   the hash is built in two stages: 16x8 multiply of sum and xor, then a 32-bit add.
// reset
//   clears the scan state, offsets, entry count, queue fill and stage valids, and loads hash positions 0, 1, 6, 7.
// stalls
//   when out_ready is low the output register and hash stage hold; the queue keeps
//   taking events, and in_ready drops once it is full.
`default_nettype none

module archive_index_hasher_unit
#(
    parameter int unsigned QueueDepth = aih_pkg::QUEUE_DEPTH
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [7:0]                          archive_byte,
    input  wire logic                                last_byte,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     entry_valid,
    output logic [31:0]                              name_hash,
    output logic [31:0]                              entry_offset,
    output logic                                     stream_done,
    output logic [15:0]                              entry_total,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [aih_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [aih_pkg::CFG_DATA_W-1:0]      cfg_data
);

    aih_pkg::event_t  push_ev;
    aih_pkg::event_t  pop_ev;
    logic             push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;

    assign cfg_ready = 1'b1;

    // parser and classifier
    aih_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .archive_byte (archive_byte),
        .last_byte    (last_byte),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ev_push      (push),
        .ev_data      (push_ev),
        .ev_full      (q_full)
    );

    // decoupling queue
    aih_queue #(
        .Depth (QueueDepth)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_ev),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_data  (pop_ev)
    );

    // hash unit and output register
    aih_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ev_valid     (q_valid),
        .ev_pop       (q_pop),
        .ev_data      (pop_ev),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .entry_valid  (entry_valid),
        .name_hash    (name_hash),
        .entry_offset (entry_offset),
        .stream_done  (stream_done),
        .entry_total  (entry_total)
    );

endmodule

`default_nettype wire
